// File: rtl/ltpq_pkg.sv
`default_nettype none
package ltpq_pkg;

   localparam int CAPACITY   = 64;
   localparam int NUM_KEYS   = 3;
   localparam int KEY_BITS   = 16;
   localparam int ENTRY_BITS = 32;

   localparam int CMD_W      = 2;
   localparam int KEYF_W     = 16;
   localparam int ENTRYF_W   = 32;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 7;
   localparam int KEYS_W     = 2;
   localparam int MASK_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   localparam int KEY_VEC_BITS = NUM_KEYS * KEY_BITS;
   localparam int CNT_BITS     = $clog2(CAPACITY + 1);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEYS_IN_USE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELIABLE_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNSAFE_PRUNE  = 2'd2;

   typedef struct packed {
      logic [KEY_VEC_BITS-1:0] key;
      logic [ENTRY_BITS-1:0]   payload;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      logic      front;
      entry_type new_entry;
   } cell_ctl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRYF_W-1:0] entry_out;
      logic [KEYF_W-1:0]   min_key;
      logic                dead_end;
      logic                is_empty;
      logic [OCC_W-1:0]    occupancy;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/ltpq_if.sv
`default_nettype none
interface ltpq_req_if;
   import ltpq_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [KEYF_W-1:0]   key_a;
   logic [KEYF_W-1:0]   key_b;
   logic [KEYF_W-1:0]   key_c;
   logic                to_front;
   logic [ENTRYF_W-1:0] entry_id;

   modport source (output valid, cmd, key_a, key_b, key_c, to_front, entry_id, input ready);
   modport sink (input valid, cmd, key_a, key_b, key_c, to_front, entry_id, output ready);
endinterface

interface ltpq_rsp_if;
   import ltpq_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ENTRYF_W-1:0] entry_out;
   logic [KEYF_W-1:0]   min_key;
   logic                dead_end;
   logic                is_empty;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, entry_out, min_key, dead_end, is_empty, occupancy,
                   input ready);
   modport sink (input valid, status, entry_out, min_key, dead_end, is_empty, occupancy,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/ltpq_cell.sv
`default_nettype none
module ltpq_cell
   import ltpq_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         occupied,
   input  wire entry_type    left_entry,
   input  wire logic         left_after,
   input  wire entry_type    right_entry,
   output      entry_type    entry,
   output      logic         after
);

   entry_type entry_ff;
   entry_type entry_in;

   // cell sorts behind the new key (or is empty)
   always_comb begin
      if (!occupied) begin
         after = 1'b1;
      end else if (ctl.front) begin
         after = entry_ff.key >= ctl.new_entry.key;
      end else begin
         after = entry_ff.key > ctl.new_entry.key;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.remove) begin
         entry_in = right_entry;
      end else if (ctl.insert) begin
         if (left_after) begin
            entry_in = left_entry;
         end else if (after) begin
            entry_in = ctl.new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

// File: rtl/lexicographic_tiebreak_priority_queue.sv
// Sorted priority queue of up to 64 entries keyed by up to three 16-bit keys
// (all ones = infinity), FIFO among equal keys, or ahead of them on to_front.
// Channels: req_chan carries one command (insert, remove-min, peek-min,
// clear) with keys, to_front flag and payload; rsp_chan returns one result
// per command: status, minimum payload and first key, dead-end flag, empty
// flag and occupancy. csr_* writes keys_in_use, reliable_mask and the
// first-key pruning enable; write only while no command is in flight.
// Entries live in a row of cells, sorted from cell 0 (minimum). An insert
// compares against all cells at once and each cell shifts from its left
// neighbor; a remove shifts every cell from its right neighbor.
// Timing: a transfer on req_chan is registered in the command register, the
// command executes once the result register is free, and its result is
// registered onto rsp_chan. A new command is taken only after the last one
// executes: the single command register is captured, then executed.
// Reset: queue empty, keys_in_use = 1, reliable_mask = 0, pruning enabled.
// Stall: a result held on rsp_chan does not block the next request from
// being taken; that command then waits until the result register frees.
`default_nettype none
module lexicographic_tiebreak_priority_queue
   import ltpq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   ltpq_req_if.sink                   req_chan,
   ltpq_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [KEYS_W-1:0]   keys_in_use_ff;
   logic [MASK_W-1:0]   reliable_mask_ff;
   logic                prune_first_ff;

   logic                busy_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [KEYF_W-1:0]   key_raw_ff [3];
   logic                to_front_ff;
   logic [ENTRYF_W-1:0] entry_id_ff;

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                rsp_valid_ff;
   result_type          rsp_ff;
   result_type          rsp_in;

   logic                exec;
   logic                full;
   logic                empty;
   logic [KEYS_W-1:0]   active;
   logic [KEY_BITS-1:0] key_val [3];
   logic                dead;
   logic                reliable;
   logic                all_inf;
   logic [KEY_VEC_BITS-1:0] new_key;
   cell_ctl_type        ctl;

   entry_type           cells [CAPACITY];
   logic [CAPACITY-1:0] after;
   logic [CAPACITY-1:0] occupied;

   assign req_chan.ready = !busy_ff;
   assign exec = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign full = count_ff == CNT_BITS'(CAPACITY);
   assign empty = count_ff == '0;

   always_comb begin
      active = keys_in_use_ff;
      if (active == '0) begin
         active = KEYS_W'(1);
      end else if (active > KEYS_W'(NUM_KEYS)) begin
         active = KEYS_W'(NUM_KEYS);
      end
   end

   always_comb begin
      reliable = 1'b0;
      all_inf = 1'b1;
      new_key = '0;
      for (int i = 0; i < 3; i++) begin
         key_val[i] = KEY_BITS'(key_raw_ff[i]);
      end
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (KEYS_W'(i) < active) begin
            new_key[KEY_VEC_BITS-1-i*KEY_BITS -: KEY_BITS] = key_val[i];
            if (key_val[i] == '1) begin
               if (reliable_mask_ff[i]) begin
                  reliable = 1'b1;
               end
            end else begin
               all_inf = 1'b0;
            end
         end
      end
      dead = reliable || (prune_first_ff && key_val[0] == '1) || all_inf;
   end

   always_comb begin
      ctl.insert = exec && cmd_ff == CMD_INSERT && !full;
      ctl.remove = exec && cmd_ff == CMD_REMOVE && !empty;
      ctl.front = to_front_ff;
      ctl.new_entry.key = new_key;
      ctl.new_entry.payload = ENTRY_BITS'(entry_id_ff);
   end

   always_comb begin
      count_in = count_ff;
      rsp_in.status = STATUS_OK;
      rsp_in.entry_out = '0;
      rsp_in.min_key = '0;
      rsp_in.dead_end = dead;
      case (cmd_ff)
         CMD_INSERT: begin
            if (full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         CMD_REMOVE, CMD_PEEK: begin
            if (empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.entry_out = ENTRYF_W'(cells[0].payload);
               rsp_in.min_key = KEYF_W'(cells[0].key[KEY_VEC_BITS-1 -: KEY_BITS]);
               if (cmd_ff == CMD_REMOVE) begin
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.is_empty = count_in == '0;
      rsp_in.occupancy = OCC_W'(count_in);
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign occupied[g] = CNT_BITS'(g) < count_ff;
         ltpq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occupied[g]),
            .left_entry  ((g == 0) ? ctl.new_entry : cells[(g == 0) ? 0 : g - 1]),
            .left_after  ((g == 0) ? 1'b0 : after[(g == 0) ? 0 : g - 1]),
            .right_entry ((g == CAPACITY - 1) ? cells[g] :
                          cells[(g == CAPACITY - 1) ? g : g + 1]),
            .entry       (cells[g]),
            .after       (after[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_in_use_ff <= KEYS_W'(1);
         reliable_mask_ff <= '0;
         prune_first_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KEYS_IN_USE: keys_in_use_ff <= csr_write_data[KEYS_W-1:0];
            CSR_RELIABLE_MASK: reliable_mask_ff <= csr_write_data[MASK_W-1:0];
            CSR_UNSAFE_PRUNE: prune_first_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            busy_ff <= 1'b1;
         end else if (exec) begin
            busy_ff <= 1'b0;
         end
         if (exec) begin
            count_ff <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         cmd_ff <= req_chan.cmd;
         key_raw_ff[0] <= req_chan.key_a;
         key_raw_ff[1] <= req_chan.key_b;
         key_raw_ff[2] <= req_chan.key_c;
         to_front_ff <= req_chan.to_front;
         entry_id_ff <= req_chan.entry_id;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_ff.status;
   assign rsp_chan.entry_out = rsp_ff.entry_out;
   assign rsp_chan.min_key = rsp_ff.min_key;
   assign rsp_chan.dead_end = rsp_ff.dead_end;
   assign rsp_chan.is_empty = rsp_ff.is_empty;
   assign rsp_chan.occupancy = rsp_ff.occupancy;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("insert did not grow the queue by one");

   a_remove_shift: assert property (@(posedge clock) disable iff (reset)
      ctl.remove && count_ff > CNT_BITS'(1) |=> cells[0] == $past(cells[1]))
      else $error("remove did not shift the second entry to the head");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff && !busy_ff)
      else $error("executed command left no result");

endmodule
`default_nettype wire
